// File: src/sacl_pkg.sv
// sacl_pkg: shared constants, types and register indexes for the cache lookup
// used by the other modules of set_assoc_cache_lru_lookup, not sacl_ram; no dependencies
package sacl_pkg;

  localparam int WAYS    = 4;
  localparam int SETS    = 256;
  localparam int WAY_W   = $clog2(WAYS);
  localparam int SET_W   = $clog2(SETS);
  localparam int ADDR_W  = 32;
  localparam int STAMP_W = 32;
  localparam int TAG_W   = 32;
  localparam int CNT_W   = 32;

  localparam int OFS_W   = 5;
  localparam int MASK_W  = 8;
  localparam int TSH_W   = 5;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 8;

  localparam logic [OFS_W-1:0]  OFS_RST  = OFS_W'(5);
  localparam logic [MASK_W-1:0] MASK_RST = MASK_W'(255);
  localparam logic [TSH_W-1:0]  TSH_RST  = TSH_W'(13);

  // configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    REG_OFFSET_SHIFT = 2'd0,
    REG_INDEX_MASK   = 2'd1,
    REG_TAG_SHIFT    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               vld;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  // lookup decision handed from the way selector to the top level
  typedef struct packed {
    logic             hit;
    logic             filled_empty;
    logic [WAY_W-1:0] way;
  } sel_t;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

endpackage

// File: src/sacl_ram.sv
// sacl_ram: generic single-write, single-read synchronous ram, registered read
// no package dependency
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/sacl_way_sel.sv
// sacl_way_sel: tag compare, first-invalid search and oldest-stamp victim pick
// depends on sacl_pkg
module sacl_way_sel
  import sacl_pkg::*;
(
  input  row_t             row,
  input  logic [TAG_W-1:0] tag,
  output sel_t             sel
);

  logic [WAYS-1:0]    match;
  logic [WAYS-1:0]    empty;
  logic [WAY_W-1:0]   hit_way;
  logic [WAY_W-1:0]   empty_way;
  logic [WAY_W-1:0]   old_way;
  logic [STAMP_W-1:0] old_stamp;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row[w].vld && (row[w].tag == tag);
      empty[w] = !row[w].vld;
    end
  end

  // lowest matching / lowest invalid way wins
  always_comb begin
    hit_way   = '0;
    empty_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
      if (empty[w]) empty_way = WAY_W'(w);
    end
  end

  // strict less-than keeps the lowest way on ties
  always_comb begin
    old_way   = '0;
    old_stamp = row[0].stamp;
    for (int w = 1; w < WAYS; w++) begin
      if (row[w].stamp < old_stamp) begin
        old_stamp = row[w].stamp;
        old_way   = WAY_W'(w);
      end
    end
  end

  always_comb begin
    sel.hit          = |match;
    sel.filled_empty = !(|match) && (|empty);
    if (|match) begin
      sel.way = hit_way;
    end else if (|empty) begin
      sel.way = empty_way;
    end else begin
      sel.way = old_way;
    end
  end

endmodule

// File: src/set_assoc_cache_lru_lookup.sv
// set_assoc_cache_lru_lookup: top level of the tag-only lru cache lookup
// depends on sacl_pkg, sacl_ram and sacl_way_sel
//
// usage
//   input stream: one transaction per access, in_tdata = {stamp, address}
//   result stream: one transaction per access, in the same order, carrying
//   hit, way, filled_empty and the saturating miss total
//   cfg port: cfg_we/cfg_addr/cfg_wdata write offset_shift, index_mask,
//   tag_shift; write only while no access is in flight
// timing
//   a whole set (all ways: valid, tag, stamp) is one row of a single ram;
//   accept issues the row read; then the compare step, once the output register
//   is free, compares, writes the row back and loads the output register, and
//   no new access is taken before that write-back
//   the ram read/modify/write is the limit: one access is in flight at a time,
//   so a row is always written back before the next read of it
// reset
//   rst_n (sync, active low) resets state, output valid and config registers, clears
//   the miss count and a per-set valid flag; a set whose flag is clear reads as all
//   ways invalid, tag and stamp zero, so no clearing pass of the ram is needed
// stall
//   the output register holds a result until out_tready; the block may accept
//   one more access meanwhile and waits in its compare step until it drains
module set_assoc_cache_lru_lookup
  import sacl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // cfg port
  input  logic                  cfg_we,
  input  logic [CFG_A_W-1:0]    cfg_addr,
  input  logic [CFG_D_W-1:0]    cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] address, [63:32] stamp
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [0] hit, [2:1] way, [3] filled_empty,
                                            // [35:4] miss_total, [39:36] zero
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [OFS_W-1:0]  ofs_r;
  logic [MASK_W-1:0] mask_r;
  logic [TSH_W-1:0]  tsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r  <= OFS_RST;
      mask_r <= MASK_RST;
      tsh_r  <= TSH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OFFSET_SHIFT: ofs_r  <= cfg_wdata[OFS_W-1:0];
        REG_INDEX_MASK:   mask_r <= cfg_wdata[MASK_W-1:0];
        REG_TAG_SHIFT:    tsh_r  <= cfg_wdata[TSH_W-1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  // address split
  logic [ADDR_W-1:0]  in_addr;
  logic [STAMP_W-1:0] in_stamp;
  logic [ADDR_W-1:0]  idx_full;
  logic [SET_W-1:0]   in_set;
  logic [TAG_W-1:0]   in_tag;
  logic               in_fire;

  assign in_addr  = in_tdata[ADDR_W-1:0];
  assign in_stamp = in_tdata[ADDR_W +: STAMP_W];
  assign idx_full = (in_addr >> ofs_r) & ADDR_W'(mask_r);
  // index modulo a power-of-two set count is its low bits
  assign in_set   = idx_full[SET_W-1:0];
  assign in_tag   = TAG_W'(in_addr >> tsh_r);
  assign in_fire  = in_tvalid && in_tready;

  assign in_tready = (state_r == ST_IDLE);

  // access held during the compare step
  logic [SET_W-1:0]   set_r;
  logic [TAG_W-1:0]   tag_r;
  logic [STAMP_W-1:0] stamp_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      set_r   <= in_set;
      tag_r   <= in_tag;
      stamp_r <= in_stamp;
    end
  end

  // set row ram
  logic [ROW_W-1:0] rd_data;
  logic [ROW_W-1:0] wr_data;
  logic             wr_en;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (set_r),
    .wdata (wr_data),
    .re    (in_fire),
    .raddr (in_set),
    .rdata (rd_data)
  );

  // per-set written flag, stands in for the reset contents of the ram
  logic [SETS-1:0] row_vld_r;
  row_t            cur_row;

  assign cur_row = row_vld_r[set_r] ? row_t'(rd_data) : '0;

  sel_t sel;

  sacl_way_sel u_way_sel (
    .row (cur_row),
    .tag (tag_r),
    .sel (sel)
  );

  // compare step completes when the output register is free
  logic out_free;
  logic calc_done;

  assign out_free  = !out_tvalid || out_tready;
  assign calc_done = (state_r == ST_CALC) && out_free;
  assign wr_en     = calc_done;

  // row write-back: hit refreshes stamp, miss fills or replaces the way
  row_t new_row;

  always_comb begin
    new_row = cur_row;
    new_row[sel.way].stamp = stamp_r;
    if (!sel.hit) begin
      new_row[sel.way].vld = 1'b1;
      new_row[sel.way].tag = tag_r;
    end
  end

  assign wr_data = ROW_W'(new_row);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (calc_done) begin
      row_vld_r[set_r] <= 1'b1;
    end
  end

  // saturating miss counter
  logic [CNT_W-1:0] miss_r, miss_nxt;

  always_comb begin
    miss_nxt = miss_r;
    if (!sel.hit && (miss_r != '1)) begin
      miss_nxt = miss_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_r <= '0;
    end else if (calc_done) begin
      miss_r <= miss_nxt;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_CALC;
      ST_CALC: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // output register
  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (calc_done) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (calc_done) begin
      out_data_r <= {4'b0, miss_nxt, sel.filled_empty, 2'(sel.way), sel.hit};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// File: src/sacl_checker.sv
// sacl_checker: port-level assertions for set_assoc_cache_lru_lookup
// depends on sacl_pkg; bound to the top level at the end of this file
module sacl_checker
  import sacl_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // stalled result keeps valid and data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // only one access in flight: ready drops after each accepted transaction
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second access taken during lookup");

  // a hit never reports an empty fill
  a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[3]))
    else $error("hit flagged as empty fill");

  // a new result only comes out of the compare step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without a lookup");

endmodule

bind set_assoc_cache_lru_lookup sacl_checker u_sacl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
